// File: hdl/pcc_pkg.sv
// shared types and constants for the clamped pid controller
`default_nettype none
package pcc_pkg;

  localparam int REG_WIDTH       = 16;
  localparam int OUT_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_SETPOINT = 3'd3,
    REG_OUT_MIN  = 3'd4,
    REG_OUT_MAX  = 3'd5
  } reg_index_t;

  localparam logic signed [REG_WIDTH-1:0] OUT_MIN_RESET = 16'sh8000;
  localparam logic signed [REG_WIDTH-1:0] OUT_MAX_RESET = 16'sh7fff;

  // gains and clamp limits handed to the control law
  typedef struct packed {
    logic signed [REG_WIDTH-1:0] gain_p;
    logic signed [REG_WIDTH-1:0] gain_i;
    logic signed [REG_WIDTH-1:0] gain_d;
    logic signed [REG_WIDTH-1:0] out_min;
    logic signed [REG_WIDTH-1:0] out_max;
  } law_cfg_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] control;
    logic                        clamped;
  } law_out_t;

endpackage
`default_nettype wire

// File: hdl/pcc_law.sv
// control law: weighted sum of error terms, floor shift and output clamp
`default_nettype none
module pcc_law
  import pcc_pkg::*;
#(
  parameter int ERR_WIDTH      = 17,
  parameter int ACC_WIDTH      = 32,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  law_cfg_t                     cfg,
  input  logic signed [ERR_WIDTH-1:0]  err,
  input  logic signed [ERR_WIDTH:0]    diff,
  input  logic signed [ACC_WIDTH-1:0]  integ,
  output law_out_t                     result
);

  localparam int PP_WIDTH = REG_WIDTH + ERR_WIDTH;
  localparam int PD_WIDTH = REG_WIDTH + ERR_WIDTH + 1;
  localparam int PI_WIDTH = REG_WIDTH + ACC_WIDTH;
  localparam int PMAX     = (PI_WIDTH > PD_WIDTH) ? PI_WIDTH : PD_WIDTH;
  localparam int SUM_WIDTH = PMAX + 2;

  logic signed [PP_WIDTH-1:0]  prod_p;
  logic signed [PI_WIDTH-1:0]  prod_i;
  logic signed [PD_WIDTH-1:0]  prod_d;
  logic signed [SUM_WIDTH-1:0] sum;
  logic signed [SUM_WIDTH-1:0] shifted;
  logic signed [SUM_WIDTH-1:0] lo;
  logic signed [SUM_WIDTH-1:0] hi;
  logic signed [SUM_WIDTH-1:0] ctl_lo;
  logic signed [SUM_WIDTH-1:0] ctl_hi;
  logic                        below;
  logic                        above;

  assign prod_p = cfg.gain_p * err;
  assign prod_i = cfg.gain_i * integ;
  assign prod_d = cfg.gain_d * diff;

  assign sum     = SUM_WIDTH'(prod_p) + SUM_WIDTH'(prod_i) + SUM_WIDTH'(prod_d);
  // arithmetic shift floors toward minus infinity
  assign shifted = sum >>> GAIN_FRAC_BITS;

  assign lo = SUM_WIDTH'(cfg.out_min);
  assign hi = SUM_WIDTH'(cfg.out_max);

  // lower bound first, then upper bound on the raised value
  assign below  = shifted < lo;
  assign ctl_lo = below ? lo : shifted;
  assign above  = ctl_lo > hi;
  assign ctl_hi = above ? hi : ctl_lo;

  assign result.control = ctl_hi[OUT_WIDTH-1:0];
  assign result.clamped = below | above;

endmodule
`default_nettype wire

// File: hdl/pid_controller_clamped_unit.sv
// top level of the positional pid controller with output clamp
// usage:
//   s_* carries one signed measurement per item in s_tdata.
//   m_* returns one result per item: control in m_tdata, clamp flag in m_tuser.
//   cfg_* writes the six registers (gains, setpoint, clamp limits); always ready,
//   writes to unused indexes are dropped. write only while no item is in flight.
// timing:
//   two register stages. the accept edge updates the integral and the previous
//   error and loads the error terms into the first stage; the result register
//   loads from the first stage once the output can advance (not stalled).
//   one item per cycle sustained while m_tready is high; the integral and
//   previous-error update at the accept edge is the only feedback.
// reset:
//   rst clears both stages, the integral and the previous error, and sets the
//   gains and setpoint to zero and the limits to the full 16-bit range.
// stall:
//   while m_tready is low the result holds; one more item can wait in the
//   first stage, after which s_tready drops until the result is taken.
`default_nettype none
module pid_controller_clamped_unit
  import pcc_pkg::*;
#(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int ACC_WIDTH      = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // measurement
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // control
  output logic [OUT_WIDTH-1:0]            m_tdata,
  // clamped
  output logic [0:0]                      m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [REG_WIDTH-1:0]            cfg_data
);

  localparam int ERR_WIDTH = ((DATA_WIDTH > REG_WIDTH) ? DATA_WIDTH : REG_WIDTH) + 1;
  localparam int IS_WIDTH  = ((ACC_WIDTH > ERR_WIDTH) ? ACC_WIDTH : ERR_WIDTH) + 1;
  localparam logic signed [IS_WIDTH-1:0] ACC_MAX =
    {{(IS_WIDTH-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [IS_WIDTH-1:0] ACC_MIN = ~ACC_MAX;

  // configuration registers
  logic signed [REG_WIDTH-1:0] gain_p;
  logic signed [REG_WIDTH-1:0] gain_i;
  logic signed [REG_WIDTH-1:0] gain_d;
  logic signed [REG_WIDTH-1:0] setpoint;
  logic signed [REG_WIDTH-1:0] out_min;
  logic signed [REG_WIDTH-1:0] out_max;

  // controller state
  logic signed [ACC_WIDTH-1:0] integ;
  logic signed [ERR_WIDTH-1:0] prev_err;

  // first stage
  logic                        v1;
  logic signed [ERR_WIDTH-1:0] err1;
  logic signed [ERR_WIDTH:0]   diff1;
  logic signed [ACC_WIDTH-1:0] integ1;

  // result register
  logic                        out_valid;
  law_out_t                    out_reg;

  logic                        s_fire;
  logic                        advance;
  logic signed [DATA_WIDTH-1:0] meas;
  logic signed [ERR_WIDTH-1:0] err;
  logic signed [ERR_WIDTH:0]   diff;
  logic signed [IS_WIDTH-1:0]  isum;
  logic signed [ACC_WIDTH-1:0] integ_next;
  law_cfg_t                    law_cfg;
  law_out_t                    law_res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || m_tready;
  assign s_tready  = advance || !v1;
  assign s_fire    = s_tvalid && s_tready;

  assign meas = DATA_WIDTH'(signed'(s_tdata[DATA_WIDTH-1:0]));
  assign err  = ERR_WIDTH'(setpoint) - ERR_WIDTH'(meas);
  assign diff = (ERR_WIDTH+1)'(err) - (ERR_WIDTH+1)'(prev_err);
  assign isum = IS_WIDTH'(integ) + IS_WIDTH'(err);

  always_comb begin
    if (isum > ACC_MAX) begin
      integ_next = ACC_MAX[ACC_WIDTH-1:0];
    end else if (isum < ACC_MIN) begin
      integ_next = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      integ_next = isum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p   <= '0;
      gain_i   <= '0;
      gain_d   <= '0;
      setpoint <= '0;
      out_min  <= OUT_MIN_RESET;
      out_max  <= OUT_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_GAIN_P:   gain_p   <= signed'(cfg_data);
        REG_GAIN_I:   gain_i   <= signed'(cfg_data);
        REG_GAIN_D:   gain_d   <= signed'(cfg_data);
        REG_SETPOINT: setpoint <= signed'(cfg_data);
        REG_OUT_MIN:  out_min  <= signed'(cfg_data);
        REG_OUT_MAX:  out_max  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
      v1       <= 1'b0;
    end else begin
      if (s_fire) begin
        integ    <= integ_next;
        prev_err <= err;
      end
      if (s_tready) begin
        v1 <= s_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      err1   <= err;
      diff1  <= diff;
      integ1 <= integ_next;
    end
  end

  assign law_cfg.gain_p  = gain_p;
  assign law_cfg.gain_i  = gain_i;
  assign law_cfg.gain_d  = gain_d;
  assign law_cfg.out_min = out_min;
  assign law_cfg.out_max = out_max;

  pcc_law #(
    .ERR_WIDTH      (ERR_WIDTH),
    .ACC_WIDTH      (ACC_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_law (
    .cfg    (law_cfg),
    .err    (err1),
    .diff   (diff1),
    .integ  (integ1),
    .result (law_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v1) begin
      out_reg <= law_res;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_reg.control;
  assign m_tuser[0] = out_reg.clamped;

  // an accepted item always lands in the first stage
  assert property (@(posedge clk) disable iff (rst) s_fire |=> v1)
    else $error("accepted item missing from first stage");

  // a waiting item in the first stage survives a stalled output
  assert property (@(posedge clk) disable iff (rst)
    v1 && out_valid && !m_tready |=> v1)
    else $error("first stage item lost during stall");

  // a new result only appears when the first stage held an item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(v1))
    else $error("result appeared without a source item");

  // no input accepted while both stages are full and the output stalls
  assert property (@(posedge clk) disable iff (rst)
    v1 && out_valid && !m_tready |-> !s_tready)
    else $error("input accepted with full pipeline");

endmodule
`default_nettype wire
